### sv/length_prefix_to_start_code_assert.svh
// assertion macros for the length-prefix to start-code converter
// used by length_prefix_to_start_code.sv; no other dependencies
`ifndef LENGTH_PREFIX_TO_START_CODE_ASSERT_SVH
`define LENGTH_PREFIX_TO_START_CODE_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define LPSC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lpsc: same-cycle check failed");

// consequent checked in the cycle after the antecedent
`define LPSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lpsc: next-cycle check failed");

`endif

### sv/lpsc_pkg.sv
// shared constants and types of the length-prefix to start-code converter
// no dependencies
`default_nettype none

package lpsc_pkg;

    // frame position counter width
    localparam int POSITION_BITS = 24;

    // most result bytes one input byte can cause
    localparam int BURST_MAX = 4;

    // prefix_mode register codes
    localparam logic [2:0] MODE_PASS = 3'd0;
    localparam logic [2:0] MODE_ONE  = 3'd1;
    localparam logic [2:0] MODE_TWO  = 3'd2;
    localparam logic [2:0] MODE_FOUR = 3'd3;

    // final byte of the start code 00 00 00 01, the others are zero
    localparam logic [7:0] START_CODE_LAST = 8'h01;
    localparam logic [7:0] START_CODE_ZERO = 8'h00;

    // result bytes caused by one input byte, first byte in element 0
    typedef struct packed {
        logic [BURST_MAX-1:0][7:0] bytes;
        logic [2:0]                count;
        logic                      last;
        logic                      err;
    } t_burst;

    // parser state visible to the top level
    typedef struct packed {
        logic       phase;
        logic       pass_rest;
        logic [1:0] prefix_count;
    } t_parse_stat;

endpackage

`default_nettype wire

### sv/lpsc_in_if.sv
// input byte channel: valid/ready handshake with one frame byte as payload
// depends on nothing
`default_nettype none

interface lpsc_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic [23:0] frame_length;
    logic        frame_last;

    modport source (output valid, output data_byte, output frame_length,
                    output frame_last, input ready);
    modport sink   (input valid, input data_byte, input frame_length,
                    input frame_last, output ready);
endinterface

`default_nettype wire

### sv/lpsc_out_if.sv
// output byte channel: valid/ready handshake with one result byte and its flags
// depends on nothing
`default_nettype none

interface lpsc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       burst_last;
    logic       frame_end;
    logic       frame_error;

    modport source (output valid, output out_byte, output burst_last,
                    output frame_end, output frame_error, input ready);
    modport sink   (input valid, input out_byte, input burst_last,
                    input frame_end, input frame_error, output ready);
endinterface

`default_nettype wire

### sv/lpsc_parse.sv
// prefix parser: holds the frame state and turns one input byte into a burst
// depends on lpsc_pkg
`default_nettype none

module lpsc_parse (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [2:0]           i_cfg_data,
    input  wire logic                 i_accept,
    input  wire logic [7:0]           i_byte,
    input  wire logic [23:0]          i_flen,
    input  wire logic                 i_last,
    output lpsc_pkg::t_burst          o_burst,
    output lpsc_pkg::t_parse_stat     o_stat
);

    localparam int PB = lpsc_pkg::POSITION_BITS;

    logic [2:0]    r_mode;
    logic          r_phase,  n_phase;
    logic [PB-1:0] r_pos,    n_pos;
    logic [1:0]    r_pc,     n_pc;
    logic [23:0]   r_acc,    n_acc;
    logic [23:0]   r_rem,    n_rem;
    logic          r_pass,   n_pass;
    logic [7:0]    r_held [3];
    logic [7:0]    n_held [3];

    logic [2:0]    w_psize;
    logic [31:0]   w_len;
    logic [PB-1:0] w_start;
    logic          w_tail_short;
    logic          w_len_bad;
    lpsc_pkg::t_burst w_burst;
    lpsc_pkg::t_burst w_flush;
    lpsc_pkg::t_burst w_code;

    // prefix size in bytes for the active mode
    always_comb begin
        unique case (r_mode)
            lpsc_pkg::MODE_ONE: w_psize = 3'd1;
            lpsc_pkg::MODE_TWO: w_psize = 3'd2;
            default:            w_psize = 3'd4;
        endcase
    end

    // unit length and the two frame bound checks
    assign w_len   = {r_acc, i_byte};
    assign w_start = r_pos - PB'(r_pc);
    assign w_tail_short = ({1'b0, r_pos} + (PB+1)'(w_psize)) > (PB+1)'(i_flen);
    assign w_len_bad = (w_len == 32'd1) ||
        ((34'(w_start) + 34'(w_len) + 34'd4) > 34'(i_flen));

    // held prefix bytes followed by the current byte
    always_comb begin
        w_flush = '0;
        for (int i = 0; i < lpsc_pkg::BURST_MAX; i++) begin
            if (i < 3 && 2'(i) < r_pc) begin
                w_flush.bytes[i] = r_held[i];
            end else begin
                w_flush.bytes[i] = i_byte;
            end
        end
        w_flush.count = 3'(r_pc) + 3'd1;
    end

    // trailing bytes of the start code, as many as the prefix size
    always_comb begin
        w_code = '0;
        for (int i = 0; i < lpsc_pkg::BURST_MAX; i++) begin
            w_code.bytes[i] = (3'(i) == w_psize - 3'd1) ? lpsc_pkg::START_CODE_LAST
                                                         : lpsc_pkg::START_CODE_ZERO;
        end
        w_code.count = w_psize;
    end

    // next frame state and burst for an accepted byte
    always_comb begin
        n_phase = r_phase;
        n_pos   = r_pos;
        n_pc    = r_pc;
        n_acc   = r_acc;
        n_rem   = r_rem;
        n_pass  = r_pass;
        n_held  = r_held;
        w_burst = '0;
        w_burst.bytes[0] = i_byte;

        if (i_accept) begin
            if (r_mode == lpsc_pkg::MODE_PASS) begin
                w_burst.count = 3'd1;
            end else if (r_mode > lpsc_pkg::MODE_FOUR) begin
                // unsupported mode: the frame collapses into one error result
                w_burst.bytes[0] = 8'h00;
                w_burst.err      = i_last;
                w_burst.count    = i_last ? 3'd1 : 3'd0;
            end else if (r_pass) begin
                w_burst.count = 3'd1;
            end else if (r_phase) begin
                w_burst.count = 3'd1;
                n_rem   = (r_rem != '0) ? r_rem - 24'd1 : '0;
                n_phase = (r_rem > 24'd1);
            end else if (r_pc == 2'd0 && w_tail_short) begin
                n_pass        = 1'b1;
                w_burst.count = 3'd1;
            end else if ((3'(r_pc) + 3'd1) < w_psize) begin
                n_acc = {r_acc[15:0], i_byte};
                if (r_pc != 2'd3) begin
                    n_held[r_pc] = i_byte;
                end
                n_pc = r_pc + 2'd1;
                // frame ends inside the prefix: the held bytes go out, followed by
                // the current byte twice, once in its held place and once as current
                if (i_last) begin
                    w_burst       = w_flush;
                    w_burst.count = 3'(r_pc) + 3'd2;
                end
            end else begin
                if (w_len_bad) begin
                    n_pass  = 1'b1;
                    w_burst = w_flush;
                end else begin
                    w_burst = w_code;
                    n_rem   = w_len[23:0];
                    n_phase = (w_len != 32'd0);
                end
                n_pc  = 2'd0;
                n_acc = '0;
            end

            n_pos        = r_pos + PB'(1);
            w_burst.last = i_last;

            // frame state returns to reset after the final byte
            if (i_last) begin
                n_phase = 1'b0;
                n_pos   = '0;
                n_pc    = 2'd0;
                n_acc   = '0;
                n_rem   = '0;
                n_pass  = 1'b0;
            end
        end

        // a mode write drops any half-built prefix
        if (i_cfg_we) begin
            n_phase = 1'b0;
            n_pos   = '0;
            n_pc    = 2'd0;
            n_acc   = '0;
            n_rem   = '0;
            n_pass  = 1'b0;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= lpsc_pkg::MODE_PASS;
            r_phase <= 1'b0;
            r_pos   <= '0;
            r_pc    <= 2'd0;
            r_acc   <= '0;
            r_rem   <= '0;
            r_pass  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_data;
            end
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_pc    <= n_pc;
            r_acc   <= n_acc;
            r_rem   <= n_rem;
            r_pass  <= n_pass;
        end
    end

    // held prefix bytes, read only after being written in the same prefix
    always_ff @(posedge i_clk) begin
        r_held <= n_held;
    end

    assign o_burst             = w_burst;
    assign o_stat.phase        = r_phase;
    assign o_stat.pass_rest    = r_pass;
    assign o_stat.prefix_count = r_pc;

endmodule

`default_nettype wire

### sv/lpsc_burst.sv
// output buffer: holds one burst of up to four bytes and hands them out one per transfer
// depends on lpsc_pkg
`default_nettype none

module lpsc_burst (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_load,
    input  lpsc_pkg::t_burst      i_burst,
    input  wire logic             i_ready,
    output logic                  o_load_ok,
    output logic                  o_valid,
    output logic [7:0]            o_byte,
    output logic                  o_burst_last,
    output logic                  o_frame_end,
    output logic                  o_frame_error,
    output logic [2:0]            o_count
);

    logic [lpsc_pkg::BURST_MAX-1:0][7:0] r_bytes;
    logic [2:0] r_cnt;
    logic       r_last;
    logic       r_err;
    logic       w_take;

    assign w_take    = o_valid && i_ready;
    // room for a new burst when empty or once the last byte leaves in this cycle
    assign o_load_ok = (r_cnt == 3'd0) || (r_cnt == 3'd1 && i_ready);

    // byte count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 3'd0;
        end else if (i_load) begin
            r_cnt <= i_burst.count;
        end else if (w_take) begin
            r_cnt <= r_cnt - 3'd1;
        end
    end

    // burst bytes, shifted down by one byte per transfer
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bytes <= i_burst.bytes;
            r_last  <= i_burst.last;
            r_err   <= i_burst.err;
        end else if (w_take) begin
            r_bytes <= r_bytes >> 8;
        end
    end

    assign o_valid       = (r_cnt != 3'd0);
    assign o_byte        = r_bytes[0];
    assign o_burst_last  = (r_cnt == 3'd1);
    assign o_frame_end   = (r_cnt == 3'd1) && r_last;
    assign o_frame_error = r_err;
    assign o_count       = r_cnt;

endmodule

`default_nettype wire

### sv/length_prefix_to_start_code.sv
// the first result of an input byte is offered in the cycle after its transfer
// throughput: one byte per cycle while each byte gives one result and the output is ready;
// a byte that gives n results (start code or flushed prefix) holds the output buffer until
// all n have left, and the next input transfer is taken in the cycle its last result leaves
// reset (synchronous, active low): mode pass-through, frame state cleared, buffer empty
// depends on lpsc_pkg, lpsc_in_if, lpsc_out_if, lpsc_parse, lpsc_burst
`default_nettype none

`include "length_prefix_to_start_code_assert.svh"

module length_prefix_to_start_code (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [2:0] i_cfg_data,
    lpsc_in_if.sink         i_in,
    lpsc_out_if.source      o_out
);

    lpsc_pkg::t_burst      w_burst;
    lpsc_pkg::t_parse_stat w_stat;
    logic       w_load_ok;
    logic       w_in_xfer;
    logic [2:0] w_buf_count;

    // input transfer whenever the buffer can take the next burst
    assign i_in.ready = w_load_ok;
    assign w_in_xfer  = i_in.valid && w_load_ok;

    // frame parser
    lpsc_parse u_parse (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_accept   (w_in_xfer),
        .i_byte     (i_in.data_byte),
        .i_flen     (i_in.frame_length),
        .i_last     (i_in.frame_last),
        .o_burst    (w_burst),
        .o_stat     (w_stat)
    );

    // result buffer
    lpsc_burst u_burst (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (w_in_xfer),
        .i_burst       (w_burst),
        .i_ready       (o_out.ready),
        .o_load_ok     (w_load_ok),
        .o_valid       (o_out.valid),
        .o_byte        (o_out.out_byte),
        .o_burst_last  (o_out.burst_last),
        .o_frame_end   (o_out.frame_end),
        .o_frame_error (o_out.frame_error),
        .o_count       (w_buf_count)
    );

    // a new burst never overwrites more than the byte leaving now
    `LPSC_ASSERT_SAME(a_no_overwrite, i_clk, i_rst_n, w_in_xfer, w_buf_count <= 3'd1)
    // an error result is always alone and closes the frame
    `LPSC_ASSERT_SAME(a_err_alone, i_clk, i_rst_n, o_out.valid && o_out.frame_error, o_out.burst_last && o_out.frame_end)
    // a mode write leaves the parser at the start of a prefix
    `LPSC_ASSERT_NEXT(a_cfg_clears, i_clk, i_rst_n, i_cfg_we, !w_stat.phase && !w_stat.pass_rest && w_stat.prefix_count == 2'd0)
    // the final byte of a frame leaves the parser at the start of a prefix
    `LPSC_ASSERT_NEXT(a_last_clears, i_clk, i_rst_n, w_in_xfer && i_in.frame_last, !w_stat.phase && !w_stat.pass_rest && w_stat.prefix_count == 2'd0)

endmodule

`default_nettype wire
